[rtl/roman_numeral_emitter_assert.svh]
// Assertion macros shared by the roman numeral emitter RTL.
`ifndef ROMAN_NUMERAL_EMITTER_ASSERT_SVH
`define ROMAN_NUMERAL_EMITTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define RNE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define RNE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RNE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RNE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/rne_pkg.sv]
// Types, constants and letter tables for the roman numeral emitter.
`default_nettype none
package rne_pkg;

  // Number of digit slots the datapath is built for.
  localparam int DIGIT_SLOTS = 4;

  // Divide by ten as a multiply by 2^19/10, exact for values below 43690.
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // ASCII codes of the characters the block can send.
  localparam logic [6:0] CH_ZERO = 7'h30;
  localparam logic [6:0] CH_I    = 7'h69;
  localparam logic [6:0] CH_X    = 7'h78;
  localparam logic [6:0] CH_C    = 7'h63;
  localparam logic [6:0] CH_M    = 7'h6d;
  localparam logic [6:0] CH_Z    = 7'h7a;
  localparam logic [6:0] CH_V    = 7'h76;
  localparam logic [6:0] CH_L    = 7'h6c;
  localparam logic [6:0] CH_D    = 7'h64;
  localparam logic [6:0] CH_W    = 7'h77;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SPLIT,
    ST_EMIT
  } rne_state_t;

  // Letter worth one unit of the given decimal place.
  function automatic logic [6:0] unit_letter(input logic [2:0] place);
    logic [6:0] ch;
    case (place)
      3'd0:    ch = CH_I;
      3'd1:    ch = CH_X;
      3'd2:    ch = CH_C;
      3'd3:    ch = CH_M;
      default: ch = CH_Z;
    endcase
    return ch;
  endfunction

  // Letter worth five units of the given decimal place.
  function automatic logic [6:0] half_letter(input logic [1:0] place);
    logic [6:0] ch;
    case (place)
      2'd0:    ch = CH_V;
      2'd1:    ch = CH_L;
      2'd2:    ch = CH_D;
      default: ch = CH_W;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[rtl/roman_numeral_emitter.sv]
// Top level of the roman numeral emitter: digit split and character sequencer.
`default_nettype none
// Converts a page number into its lower-case Roman numeral and sends it one ASCII
// character per request, most significant decimal digit first, with out_last set on
// the final character; zero sends the single character '0', and values above
// 10^MAX_DIGITS - 1 are clamped to that maximum. A number is accepted in the idle state,
// then split into decimal digits in ST_SPLIT, where a single reciprocal multiplier
// divides by ten, then ST_EMIT sends the characters and steps over each zero digit
// inside the number, waiting while the output register is full and out_ready is low.
// in_ready is high only while the sequencer is idle; the last character may still
// wait in the output register when the next number is taken.
module roman_numeral_emitter
  import rne_pkg::*;
#(
  parameter int MAX_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [13:0] in_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char_code,
  output logic             out_last
);

`include "roman_numeral_emitter_assert.svh"

  localparam logic [13:0] LIMIT = 14'((10 ** MAX_DIGITS) - 1);
  localparam logic [1:0]  TOP_PLACE = 2'(MAX_DIGITS - 1);

  rne_state_t  state_r, state_nxt;
  logic [13:0] value_r, value_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  p_r, p_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [3:0]  nz_r, nz_nxt;
  logic [3:0]  digits_r [DIGIT_SLOTS];
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_acc;
  logic [13:0] sat_value;
  logic [29:0] prod;
  logic [13:0] quot;
  logic [3:0]  rem10;
  logic        split_done;
  logic        can_load;
  logic [3:0]  cur_digit;
  logic        five_sel;
  logic [2:0]  rmd;
  logic [2:0]  dig_len;
  logic [6:0]  emit_char;
  logic        digit_end;
  logic        lower_zero;
  logic        run_end;
  logic [3:0]  low_mask;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;

  // Clamp the incoming value to the largest number the digit count can show.
  assign sat_value = (in_number > LIMIT) ? LIMIT : in_number;

  // Shared divide-by-ten unit: quotient by reciprocal, remainder by shift, add and subtract.
  assign prod  = 30'(value_r) * 30'(DIV10_RECIP);
  assign quot  = 14'(prod >> DIV10_SHIFT);
  assign rem10 = 4'(value_r - ((quot << 3) + (quot << 1)));
  assign split_done = (quot == 14'd0);

  // Decode the current digit into its character pattern.
  assign cur_digit = digits_r[p_r];
  assign five_sel  = (cur_digit >= 4'd5);
  assign rmd       = five_sel ? 3'(cur_digit - 4'd5) : cur_digit[2:0];
  assign dig_len   = (rmd == 3'd4) ? 3'd2 : (3'(five_sel) + rmd);
  assign low_mask  = (4'b0001 << p_r) - 4'b0001;
  assign lower_zero = ((nz_r & low_mask) == 4'b0000);
  assign digit_end = (k_r == (dig_len - 3'd1));
  assign run_end   = digit_end && lower_zero;

  always_comb begin
    if (rmd == 3'd4) begin
      if (k_r == 3'd0) begin
        emit_char = unit_letter({1'b0, p_r});
      end else if (five_sel) begin
        emit_char = unit_letter(3'({1'b0, p_r}) + 3'd1);
      end else begin
        emit_char = half_letter(p_r);
      end
    end else if (five_sel && (k_r == 3'd0)) begin
      emit_char = half_letter(p_r);
    end else begin
      emit_char = unit_letter({1'b0, p_r});
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (sat_value == 14'd0) ? ST_ZERO : ST_SPLIT;
        end
      end
      ST_ZERO: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SPLIT: begin
        if (split_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if ((dig_len != 3'd0) && can_load && run_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    value_nxt     = value_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    nz_nxt        = nz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          value_nxt = sat_value;
          cnt_nxt   = 2'd0;
          k_nxt     = 3'd0;
          nz_nxt    = 4'b0000;
        end
      end
      ST_ZERO: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO;
          out_last_nxt  = 1'b1;
        end
      end
      ST_SPLIT: begin
        value_nxt = quot;
        nz_nxt[cnt_r] = (rem10 != 4'd0);
        if (split_done) begin
          p_nxt = cnt_r;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if (dig_len == 3'd0) begin
          // A zero digit inside the number sends nothing.
          p_nxt = p_r - 2'd1;
          k_nxt = 3'd0;
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_char;
          out_last_nxt  = run_end;
          if (digit_end) begin
            p_nxt = p_r - 2'd1;
            k_nxt = 3'd0;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    cnt_r      <= cnt_nxt;
    p_r        <= p_nxt;
    k_r        <= k_nxt;
    nz_r       <= nz_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit store, written once per split cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_SPLIT) begin
      digits_r[cnt_r] <= rem10;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  `RNE_ASSERT_IMP(a_split_in_range, clk, rst_n,
    (state_r == ST_SPLIT) && !split_done, cnt_r != TOP_PLACE,
    "digit split ran past the top decimal place")
  `RNE_ASSERT_NEXT(a_leading_digit, clk, rst_n,
    (state_r == ST_SPLIT) && split_done, cur_digit != 4'd0,
    "emission started on a zero leading digit")
  `RNE_ASSERT_NEXT(a_accept_starts_work, clk, rst_n,
    in_acc, (state_r == ST_SPLIT) || (state_r == ST_ZERO),
    "accepted request did not start a conversion")
  `RNE_ASSERT_IMP(a_digit_range, clk, rst_n,
    state_r == ST_EMIT, cur_digit <= 4'd9,
    "digit store holds a value above nine")

endmodule
`default_nettype wire
